// File: rtl/core/random_dfs_maze_carver_unit_defines.svh
// ----------------------------------------------------------------------------
// Maze carver assertion macros
// Shared concurrent assertion forms for the maze carver checker.
// ----------------------------------------------------------------------------
`ifndef RANDOM_DFS_MAZE_CARVER_UNIT_DEFINES_SVH
`define RANDOM_DFS_MAZE_CARVER_UNIT_DEFINES_SVH

// same-cycle implication
`define RDMC_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rdmc: same-cycle check failed");

// next-cycle implication
`define RDMC_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rdmc: next-cycle check failed");

`endif

// File: rtl/core/rdmc_pkg.sv
// ----------------------------------------------------------------------------
// Maze carver package
// Widths, direction codes, direction orderings and shared types.
// ----------------------------------------------------------------------------
package rdmc_pkg;

    localparam int MAX_CELLS_PER_SIDE = 32;
    localparam int CFG_W              = 6;
    localparam int PICK_W             = 5;
    localparam int NEXT_W             = 3;
    localparam int OUT_W              = 6;
    localparam int DIR_W              = 2;
    localparam int EPOCH_W            = 8;
    localparam int NUM_ORDERS         = 24;

    localparam logic [CFG_W-1:0]  CFG_RESET = 6'd5;
    localparam logic [PICK_W-1:0] PICK_WRAP = 5'd24;

    typedef enum logic [DIR_W-1:0] {
        DIR_EAST  = 2'd0,
        DIR_SOUTH = 2'd1,
        DIR_WEST  = 2'd2,
        DIR_NORTH = 2'd3
    } t_dir;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_TRY,
        S_CHECK,
        S_POP
    } t_state;

    // one candidate move of the top frame
    typedef struct packed {
        t_dir             dir;
        logic             exhausted;
        logic             in_bounds;
        logic [OUT_W-1:0] wall_row;
        logic [OUT_W-1:0] wall_col;
        logic [OUT_W-1:0] cell_row;
        logic [OUT_W-1:0] cell_col;
    } t_step;

    // lexicographic orderings, position 0 in the low bits
    localparam logic [7:0] ORDER_TAB [NUM_ORDERS] = '{
        {2'd3, 2'd2, 2'd1, 2'd0}, {2'd2, 2'd3, 2'd1, 2'd0},
        {2'd3, 2'd1, 2'd2, 2'd0}, {2'd1, 2'd3, 2'd2, 2'd0},
        {2'd2, 2'd1, 2'd3, 2'd0}, {2'd1, 2'd2, 2'd3, 2'd0},
        {2'd3, 2'd2, 2'd0, 2'd1}, {2'd2, 2'd3, 2'd0, 2'd1},
        {2'd3, 2'd0, 2'd2, 2'd1}, {2'd0, 2'd3, 2'd2, 2'd1},
        {2'd2, 2'd0, 2'd3, 2'd1}, {2'd0, 2'd2, 2'd3, 2'd1},
        {2'd3, 2'd1, 2'd0, 2'd2}, {2'd1, 2'd3, 2'd0, 2'd2},
        {2'd3, 2'd0, 2'd1, 2'd2}, {2'd0, 2'd3, 2'd1, 2'd2},
        {2'd1, 2'd0, 2'd3, 2'd2}, {2'd0, 2'd1, 2'd3, 2'd2},
        {2'd2, 2'd1, 2'd0, 2'd3}, {2'd1, 2'd2, 2'd0, 2'd3},
        {2'd2, 2'd0, 2'd1, 2'd3}, {2'd0, 2'd2, 2'd1, 2'd3},
        {2'd1, 2'd0, 2'd2, 2'd3}, {2'd0, 2'd1, 2'd2, 2'd3}
    };

    function automatic logic [PICK_W-1:0] wrap_pick(input logic [PICK_W-1:0] p);
        return (p >= PICK_WRAP) ? p - PICK_WRAP : p;
    endfunction

    function automatic t_dir order_dir(input logic [PICK_W-1:0] pick,
                                       input logic [1:0]        pos);
        logic [7:0] row;
        row = ORDER_TAB[pick];
        return t_dir'(row[{pos, 1'b0} +: 2]);
    endfunction

endpackage

// File: rtl/core/random_dfs_maze_carver_unit.sv
// ----------------------------------------------------------------------------
// Randomised depth-first maze carver
// Recursive backtracker with the visited map and path stack held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one word per carve: a random
//   pick 0..23 (24..31 wrap) choosing the direction order of the current cell.
//   Output channel (o_out_valid / i_out_ready) gives one carve per input word:
//   wall square, new cell, direction and a last flag on the maze's final cell.
//   The word after a last carve starts a new maze at cell (1,1).
//   Config channel (i_cfg_valid / o_cfg_ready) sets cells per side (clamped
//   to 2..MAX); a write abandons any maze in progress. Always ready.
// Search steps:
//   Each input is accepted in S_IDLE; the search visits S_TRY per out-of-grid
//   direction, S_TRY and S_CHECK per direction checked in the visited RAM,
//   S_TRY and S_POP per frame popped from the stack RAM and S_START for a
//   fresh maze. The visited-map RAM read/modify/write loop sets the rate.
// Reset and stalls:
//   After reset a clearing pass sweeps all 2^(2*clog2(MAX)) visited-map
//   entries (1024 by default); the same pass runs once every 255 mazes when the
//   epoch mark wraps. A new word is taken while a carve waits in the output
//   register; its search stalls before its own carve until that word leaves.
// ----------------------------------------------------------------------------
module random_dfs_maze_carver_unit #(
    parameter int MAX_CELLS_PER_SIDE = rdmc_pkg::MAX_CELLS_PER_SIDE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rdmc_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [rdmc_pkg::PICK_W-1:0] i_rand_pick,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rdmc_pkg::OUT_W-1:0]  o_wall_row,
    output logic [rdmc_pkg::OUT_W-1:0]  o_wall_col,
    output logic [rdmc_pkg::OUT_W-1:0]  o_cell_row,
    output logic [rdmc_pkg::OUT_W-1:0]  o_cell_col,
    output logic [rdmc_pkg::DIR_W-1:0]  o_direction,
    output logic                        o_last
);

    localparam int CW     = $clog2(MAX_CELLS_PER_SIDE);
    localparam int SW     = $clog2(MAX_CELLS_PER_SIDE + 1);
    localparam int VAW    = 2 * CW;
    localparam int VDEPTH = 1 << VAW;
    localparam int SDEPTH = MAX_CELLS_PER_SIDE * MAX_CELLS_PER_SIDE;
    localparam int SAW    = $clog2(SDEPTH);
    localparam int DW     = $clog2(SDEPTH + 1);
    localparam int LW     = $clog2(SDEPTH);
    localparam int PW     = rdmc_pkg::PICK_W;
    localparam int NW     = rdmc_pkg::NEXT_W;
    localparam int EW     = rdmc_pkg::EPOCH_W;
    localparam int FW     = 2 * CW + PW + NW;
    localparam logic [7:0] MAX8 = 8'(MAX_CELLS_PER_SIDE);

    // control
    rdmc_pkg::t_state     r_state, n_state;
    logic                 r_active, n_active;
    logic [EW-1:0]        r_epoch, n_epoch;
    logic [DW-1:0]        r_depth, n_depth;
    logic [LW-1:0]        r_left, n_left;
    logic [VAW-1:0]       r_clr_addr, n_clr_addr;
    logic                 r_resume, n_resume;
    logic                 r_out_valid, n_out_valid;
    logic [rdmc_pkg::CFG_W-1:0] r_cfg;

    // payload
    logic [PW-1:0]        r_pick_hold, n_pick_hold;
    logic [CW-1:0]        r_cur_row, n_cur_row, r_cur_col, n_cur_col;
    logic [PW-1:0]        r_cur_pick, n_cur_pick;
    logic [NW-1:0]        r_cur_next, n_cur_next;
    logic [CW-1:0]        r_nb_row, n_nb_row, r_nb_col, n_nb_col;
    rdmc_pkg::t_step      r_step, n_step;
    logic [rdmc_pkg::OUT_W-1:0] r_wall_row, n_wall_row, r_wall_col, n_wall_col;
    logic [rdmc_pkg::OUT_W-1:0] r_cell_row, n_cell_row, r_cell_col, n_cell_col;
    logic [rdmc_pkg::DIR_W-1:0] r_dir, n_dir;
    logic                 r_last, n_last;

    // memory ports
    logic                 w_vis_we, w_vis_re;
    logic [VAW-1:0]       w_vis_waddr, w_vis_raddr;
    logic [EW-1:0]        w_vis_wdata, w_vis_rdata;
    logic                 w_stk_we, w_stk_re;
    logic [SAW-1:0]       w_stk_waddr, w_stk_raddr;
    logic [FW-1:0]        w_stk_wdata, w_stk_rdata;

    logic                 w_in_acc, w_cfg_acc;
    logic [7:0]           w_cfg8, w_side8;
    logic [SW-1:0]        w_side;
    logic [2*SW-1:0]      w_area;
    logic [LW-1:0]        w_left_dec;
    logic [DW-1:0]        w_push_idx, w_pop_idx;
    logic [PW-1:0]        w_pick;
    logic [CW-1:0]        w_nb_row, w_nb_col;
    rdmc_pkg::t_step      w_step;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == rdmc_pkg::S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_pick      = rdmc_pkg::wrap_pick(i_rand_pick);

    // clamp the size register to 2..MAX
    always_comb begin
        w_cfg8  = 8'(r_cfg);
        w_side8 = (w_cfg8 < 8'd2) ? 8'd2 : ((w_cfg8 > MAX8) ? MAX8 : w_cfg8);
        w_side  = w_side8[SW-1:0];
        w_area  = (2*SW)'(w_side) * (2*SW)'(w_side);
    end

    assign w_left_dec = (r_left != '0) ? r_left - LW'(1) : r_left;
    assign w_push_idx = r_depth - DW'(1);
    assign w_pop_idx  = r_depth - DW'(2);

    rdmc_walker #(
        .MAX_CELLS_PER_SIDE (MAX_CELLS_PER_SIDE)
    ) u_walker (
        .i_side   (w_side),
        .i_row    (r_cur_row),
        .i_col    (r_cur_col),
        .i_pick   (r_cur_pick),
        .i_next   (r_cur_next),
        .o_nb_row (w_nb_row),
        .o_nb_col (w_nb_col),
        .o_step   (w_step)
    );

    // visited map: entry holds the epoch of the maze that visited it
    rdmc_ram #(
        .WIDTH (EW),
        .DEPTH (VDEPTH)
    ) u_visited (
        .i_clk   (i_clk),
        .i_we    (w_vis_we),
        .i_waddr (w_vis_waddr),
        .i_wdata (w_vis_wdata),
        .i_re    (w_vis_re),
        .i_raddr (w_vis_raddr),
        .o_rdata (w_vis_rdata)
    );

    // path stack: frames below the top, top frame lives in r_cur_*
    rdmc_ram #(
        .WIDTH (FW),
        .DEPTH (SDEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_stk_wdata),
        .i_re    (w_stk_re),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_epoch     = r_epoch;
        n_depth     = r_depth;
        n_left      = r_left;
        n_clr_addr  = r_clr_addr;
        n_resume    = r_resume;
        n_pick_hold = r_pick_hold;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_cur_pick  = r_cur_pick;
        n_cur_next  = r_cur_next;
        n_nb_row    = r_nb_row;
        n_nb_col    = r_nb_col;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        n_wall_row  = r_wall_row;
        n_wall_col  = r_wall_col;
        n_cell_row  = r_cell_row;
        n_cell_col  = r_cell_col;
        n_dir       = r_dir;
        n_last      = r_last;

        w_vis_we    = 1'b0;
        w_vis_waddr = '0;
        w_vis_wdata = '0;
        w_vis_re    = 1'b0;
        w_vis_raddr = {w_nb_row, w_nb_col};
        w_stk_we    = 1'b0;
        w_stk_waddr = w_push_idx[SAW-1:0];
        w_stk_wdata = {r_cur_row, r_cur_col, r_cur_pick, r_cur_next};
        w_stk_re    = 1'b0;
        w_stk_raddr = w_pop_idx[SAW-1:0];

        case (r_state)
            rdmc_pkg::S_CLEAR: begin
                w_vis_we    = 1'b1;
                w_vis_waddr = r_clr_addr;
                n_clr_addr  = r_clr_addr + VAW'(1);
                if (&r_clr_addr) begin
                    if (r_resume) begin
                        n_epoch  = EW'(1);
                        n_resume = 1'b0;
                        n_state  = rdmc_pkg::S_START;
                    end else begin
                        n_state  = rdmc_pkg::S_IDLE;
                    end
                end
            end
            rdmc_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (!r_active) begin
                        n_pick_hold = w_pick;
                        if (&r_epoch) begin
                            // epoch about to wrap: sweep the map first
                            n_resume = 1'b1;
                            n_state  = rdmc_pkg::S_CLEAR;
                        end else begin
                            n_epoch  = r_epoch + EW'(1);
                            n_state  = rdmc_pkg::S_START;
                        end
                    end else if (r_depth == '0) begin
                        n_active = 1'b0;
                    end else begin
                        n_cur_pick = w_pick;
                        n_cur_next = '0;
                        n_state    = rdmc_pkg::S_TRY;
                    end
                end
            end
            rdmc_pkg::S_START: begin
                w_vis_we    = 1'b1;
                w_vis_waddr = '0;
                w_vis_wdata = r_epoch;
                n_depth     = DW'(1);
                n_left      = LW'(w_area - (2*SW)'(1));
                n_cur_row   = '0;
                n_cur_col   = '0;
                n_cur_pick  = r_pick_hold;
                n_cur_next  = '0;
                n_active    = 1'b1;
                n_state     = rdmc_pkg::S_TRY;
            end
            rdmc_pkg::S_TRY: begin
                if (!r_out_valid) begin
                    if (w_step.exhausted) begin
                        if (r_depth == DW'(1)) begin
                            n_depth  = '0;
                            n_active = 1'b0;
                            n_state  = rdmc_pkg::S_IDLE;
                        end else begin
                            n_depth  = w_push_idx;
                            w_stk_re = 1'b1;
                            n_state  = rdmc_pkg::S_POP;
                        end
                    end else begin
                        n_cur_next = r_cur_next + NW'(1);
                        if (w_step.in_bounds) begin
                            w_vis_re = 1'b1;
                            n_nb_row = w_nb_row;
                            n_nb_col = w_nb_col;
                            n_step   = w_step;
                            n_state  = rdmc_pkg::S_CHECK;
                        end
                    end
                end
            end
            rdmc_pkg::S_POP: begin
                {n_cur_row, n_cur_col, n_cur_pick, n_cur_next} = w_stk_rdata;
                n_state = rdmc_pkg::S_TRY;
            end
            rdmc_pkg::S_CHECK: begin
                if (w_vis_rdata == r_epoch) begin
                    n_state = rdmc_pkg::S_TRY;
                end else begin
                    // carve: mark, push the old top, enter the neighbour
                    w_vis_we    = 1'b1;
                    w_vis_waddr = {r_nb_row, r_nb_col};
                    w_vis_wdata = r_epoch;
                    w_stk_we    = 1'b1;
                    n_depth     = r_depth + DW'(1);
                    n_left      = w_left_dec;
                    n_cur_row   = r_nb_row;
                    n_cur_col   = r_nb_col;
                    n_cur_pick  = '0;
                    n_cur_next  = '0;
                    n_out_valid = 1'b1;
                    n_wall_row  = r_step.wall_row;
                    n_wall_col  = r_step.wall_col;
                    n_cell_row  = r_step.cell_row;
                    n_cell_col  = r_step.cell_col;
                    n_dir       = r_step.dir;
                    n_last      = (w_left_dec == '0);
                    if (w_left_dec == '0) begin
                        n_active = 1'b0;
                    end
                    n_state     = rdmc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rdmc_pkg::S_IDLE;
            end
        endcase

        if (w_cfg_acc) begin
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rdmc_pkg::S_CLEAR;
            r_active    <= 1'b0;
            r_epoch     <= '0;
            r_depth     <= '0;
            r_left      <= '0;
            r_clr_addr  <= '0;
            r_resume    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg       <= rdmc_pkg::CFG_RESET;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_epoch     <= n_epoch;
            r_depth     <= n_depth;
            r_left      <= n_left;
            r_clr_addr  <= n_clr_addr;
            r_resume    <= n_resume;
            r_out_valid <= n_out_valid;
            if (w_cfg_acc) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pick_hold <= n_pick_hold;
        r_cur_row   <= n_cur_row;
        r_cur_col   <= n_cur_col;
        r_cur_pick  <= n_cur_pick;
        r_cur_next  <= n_cur_next;
        r_nb_row    <= n_nb_row;
        r_nb_col    <= n_nb_col;
        r_step      <= n_step;
        r_wall_row  <= n_wall_row;
        r_wall_col  <= n_wall_col;
        r_cell_row  <= n_cell_row;
        r_cell_col  <= n_cell_col;
        r_dir       <= n_dir;
        r_last      <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_wall_row  = r_wall_row;
    assign o_wall_col  = r_wall_col;
    assign o_cell_row  = r_cell_row;
    assign o_cell_col  = r_cell_col;
    assign o_direction = r_dir;
    assign o_last      = r_last;

endmodule

// File: rtl/core/rdmc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rdmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/rdmc_walker.sv
// ----------------------------------------------------------------------------
// Maze carver neighbour step
// Picks the direction for the frame's next ordering position, checks it
// against the grid and works out the neighbour, wall and output coordinates.
// ----------------------------------------------------------------------------
module rdmc_walker #(
    parameter int  MAX_CELLS_PER_SIDE = rdmc_pkg::MAX_CELLS_PER_SIDE,
    localparam int CW = $clog2(MAX_CELLS_PER_SIDE),
    localparam int SW = $clog2(MAX_CELLS_PER_SIDE + 1)
) (
    input  logic [SW-1:0]               i_side,
    input  logic [CW-1:0]               i_row,
    input  logic [CW-1:0]               i_col,
    input  logic [rdmc_pkg::PICK_W-1:0] i_pick,
    input  logic [rdmc_pkg::NEXT_W-1:0] i_next,
    output logic [CW-1:0]               o_nb_row,
    output logic [CW-1:0]               o_nb_col,
    output rdmc_pkg::t_step             o_step
);

    logic [7:0]     w_row8, w_col8, w_side8, w_row2, w_col2;
    logic [7:0]     w_wall_row, w_wall_col, w_cell_row, w_cell_col;
    rdmc_pkg::t_dir w_dir;
    logic           w_inb;

    always_comb begin
        w_row8  = 8'(i_row);
        w_col8  = 8'(i_col);
        w_side8 = 8'(i_side);
        // grid coordinate of the cell itself: 2*idx+1
        w_row2  = {w_row8[6:0], 1'b0} + 8'd1;
        w_col2  = {w_col8[6:0], 1'b0} + 8'd1;
        w_dir   = rdmc_pkg::order_dir(i_pick, i_next[1:0]);

        w_inb      = 1'b0;
        o_nb_row   = i_row;
        o_nb_col   = i_col;
        w_wall_row = w_row2;
        w_wall_col = w_col2;
        w_cell_row = w_row2;
        w_cell_col = w_col2;

        case (w_dir)
            rdmc_pkg::DIR_EAST: begin
                w_inb      = (w_col8 + 8'd1) < w_side8;
                o_nb_col   = i_col + CW'(1);
                w_wall_col = w_col2 + 8'd1;
                w_cell_col = w_col2 + 8'd2;
            end
            rdmc_pkg::DIR_SOUTH: begin
                w_inb      = (w_row8 + 8'd1) < w_side8;
                o_nb_row   = i_row + CW'(1);
                w_wall_row = w_row2 + 8'd1;
                w_cell_row = w_row2 + 8'd2;
            end
            rdmc_pkg::DIR_WEST: begin
                w_inb      = (i_col != '0);
                o_nb_col   = i_col - CW'(1);
                w_wall_col = w_col2 - 8'd1;
                w_cell_col = w_col2 - 8'd2;
            end
            rdmc_pkg::DIR_NORTH: begin
                w_inb      = (i_row != '0);
                o_nb_row   = i_row - CW'(1);
                w_wall_row = w_row2 - 8'd1;
                w_cell_row = w_row2 - 8'd2;
            end
            default: begin
                w_inb = 1'b0;
            end
        endcase

        o_step.dir       = w_dir;
        o_step.exhausted = i_next[2];
        o_step.in_bounds = w_inb;
        o_step.wall_row  = w_wall_row[rdmc_pkg::OUT_W-1:0];
        o_step.wall_col  = w_wall_col[rdmc_pkg::OUT_W-1:0];
        o_step.cell_row  = w_cell_row[rdmc_pkg::OUT_W-1:0];
        o_step.cell_col  = w_cell_col[rdmc_pkg::OUT_W-1:0];
    end

endmodule

// File: rtl/core/rdmc_checker.sv
// ----------------------------------------------------------------------------
// Maze carver port checker
// Watches the result channel of the carver top level.
// ----------------------------------------------------------------------------
`include "random_dfs_maze_carver_unit_defines.svh"

module rdmc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_ready,
    input logic                        o_out_valid,
    input logic [rdmc_pkg::OUT_W-1:0]  o_wall_row,
    input logic [rdmc_pkg::OUT_W-1:0]  o_wall_col,
    input logic [rdmc_pkg::OUT_W-1:0]  o_cell_row,
    input logic [rdmc_pkg::OUT_W-1:0]  o_cell_col,
    input logic [rdmc_pkg::DIR_W-1:0]  o_direction
);

    logic                                  w_stall;
    logic                                  w_horiz;
    logic                                  w_vert;
    logic [4*rdmc_pkg::OUT_W+rdmc_pkg::DIR_W-1:0] w_carve;

    assign w_stall = o_out_valid && !i_out_ready;
    assign w_horiz = (o_direction == rdmc_pkg::DIR_EAST) || (o_direction == rdmc_pkg::DIR_WEST);
    assign w_vert  = (o_direction == rdmc_pkg::DIR_SOUTH) || (o_direction == rdmc_pkg::DIR_NORTH);
    assign w_carve = {o_wall_row, o_wall_col, o_cell_row, o_cell_col, o_direction};

    // a stalled word holds
    `RDMC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, o_out_valid && $stable(w_carve))

    // cells sit at odd coordinates
    `RDMC_ASSERT_NOW(a_cell_odd, i_clk, i_rst_n, o_out_valid, o_cell_row[0] && o_cell_col[0])

    // a horizontal move opens a wall on the cell's own row
    `RDMC_ASSERT_NOW(a_wall_row, i_clk, i_rst_n, o_out_valid && w_horiz, o_wall_row == o_cell_row)

    // a vertical move opens a wall on the cell's own column
    `RDMC_ASSERT_NOW(a_wall_col, i_clk, i_rst_n, o_out_valid && w_vert, o_wall_col == o_cell_col)

endmodule

bind random_dfs_maze_carver_unit rdmc_checker u_rdmc_checker (.*);
